### design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, operation and status codes, and the entry memory request
// type of the linear key-value table.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = KEY_WIDTH + VALUE_WIDTH;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // operation codes
  localparam logic [2:0] FN_LOOKUP = 3'd0;
  localparam logic [2:0] FN_ACCESS = 3'd1;
  localparam logic [2:0] FN_WRITE  = 3'd2;
  localparam logic [2:0] FN_DELETE = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_EMPTY   = 2'd1;
  localparam logic [1:0] STS_MISSING = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  // entry layout: key in the low bits, value above it
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

### design/lkv_mem.sv
// ----------------------------------------------------------------------------
// lkv_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lkv_mem (
  input  logic                         clk,
  input  lkv_pkg::mem_req_t            req,
  output logic [lkv_pkg::ENT_W-1:0]    rdata
);

  logic [lkv_pkg::ENT_W-1:0] mem [lkv_pkg::CAPACITY];
  logic [lkv_pkg::ENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/linear_key_value_table_core.sv
// ----------------------------------------------------------------------------
// linear_key_value_table_core
// Key-value table held as a packed list of entries in one memory, searched
// from entry 0 upward by a small sequencer with one key comparator.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tuser: func; tdata: key, wr_value
//  out_    | master    | tdata: rd_value, found, entry_count, status
//
//  a scan reads one entry a cycle through the memory read port, from entry 0
//  upward, and stops at the first match; an empty table skips the scan. a
//  delete that hits then moves the later entries down, one read and one write
//  a cycle (none move when it hits the last entry). in_tready is high only
//  while the sequencer is idle.
//  a finished result waits in the output register while a new transaction is
//  taken in; the sequencer holds its next result until that register is free.
//  reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module linear_key_value_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] func
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] wr_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] rd_value, [32] found,
                                  // [37:33] entry_count, [39:38] status
);

  localparam int KW = lkv_pkg::KEY_WIDTH;
  localparam int VW = lkv_pkg::VALUE_WIDTH;
  localparam int CW = lkv_pkg::CNT_W;
  localparam int IW = lkv_pkg::IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [VW-1:0] wval_r, wval_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          chk_r, chk_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [VW-1:0] hit_val_r, hit_val_nxt;
  logic [VW-1:0] res_val_r, res_val_nxt;
  logic [1:0]    res_sts_r, res_sts_nxt;
  logic [CW-1:0] sh_idx_r, sh_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_addr_r, pend_addr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  logic          out_found_r, out_found_nxt;
  logic [4:0]    out_cnt_r, out_cnt_nxt;
  logic [1:0]    out_sts_r, out_sts_nxt;

  lkv_pkg::mem_req_t          mem_req;
  logic [lkv_pkg::ENT_W-1:0]  mem_rdata;
  logic [KW-1:0]              rd_key;
  logic [VW-1:0]              rd_val;
  logic                       in_xact;
  logic [63:0]                key_ext, wval_ext, res_ext, cnt_ext;
  logic [VW-1:0]              ins_val;

  lkv_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign rd_key   = mem_rdata[KW-1:0];
  assign rd_val   = mem_rdata[lkv_pkg::ENT_W-1:KW];
  assign in_tready = (state_r == S_IDLE);
  assign in_xact  = in_tvalid && in_tready;
  assign key_ext  = 64'(in_tdata[31:0]);
  assign wval_ext = 64'(in_tdata[63:32]);
  assign res_ext  = 64'(res_val_r);
  assign cnt_ext  = 64'(count_r);
  assign ins_val  = (func_r == lkv_pkg::FN_WRITE) ? wval_r : '0;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    wval_nxt      = wval_r;
    scan_idx_nxt  = scan_idx_r;
    chk_nxt       = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    hit_val_nxt   = hit_val_r;
    res_val_nxt   = res_val_r;
    res_sts_nxt   = res_sts_r;
    sh_idx_nxt    = sh_idx_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_found_nxt = out_found_r;
    out_cnt_nxt   = out_cnt_r;
    out_sts_nxt   = out_sts_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = pend_addr_r[IW-1:0];
    mem_req.wdata = mem_rdata;
    mem_req.raddr = scan_idx_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          func_nxt   = in_tuser;
          key_nxt    = key_ext[KW-1:0];
          wval_nxt   = wval_ext[VW-1:0];
          scan_idx_nxt = '0;
          hit_nxt    = 1'b0;
          hit_val_nxt = '0;
          pos_nxt    = '0;
          state_nxt  = (count_r == '0) ? S_EXEC : S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read a cycle, compare the entry read last cycle
        if (scan_idx_r < count_r) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          chk_nxt      = 1'b1;
          chk_idx_nxt  = scan_idx_r;
        end
        if (chk_r) begin
          if (rd_key == key_r) begin
            hit_nxt     = 1'b1;
            pos_nxt     = chk_idx_r;
            hit_val_nxt = rd_val;
            chk_nxt     = 1'b0;
            state_nxt   = S_EXEC;
          end else if (chk_idx_r == count_r - 1'b1) begin
            chk_nxt   = 1'b0;
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        res_val_nxt = '0;
        res_sts_nxt = lkv_pkg::STS_OK;
        state_nxt   = S_RESP;
        case (func_r)
          lkv_pkg::FN_ACCESS, lkv_pkg::FN_WRITE: begin
            if (hit_r) begin
              if (func_r == lkv_pkg::FN_WRITE) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_r[IW-1:0];
                mem_req.wdata = {wval_r, key_r};
                res_val_nxt   = wval_r;
              end else begin
                res_val_nxt = hit_val_r;
              end
            end else if (count_r == lkv_pkg::CAP_CNT) begin
              res_sts_nxt = lkv_pkg::STS_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count_r[IW-1:0];
              mem_req.wdata = {ins_val, key_r};
              res_val_nxt   = ins_val;
              count_nxt     = count_r + 1'b1;
            end
          end
          lkv_pkg::FN_DELETE: begin
            if (count_r == '0) begin
              res_sts_nxt = lkv_pkg::STS_EMPTY;
            end else if (!hit_r) begin
              res_sts_nxt = lkv_pkg::STS_MISSING;
            end else begin
              sh_idx_nxt = pos_r + 1'b1;
              state_nxt  = S_SHIFT;
            end
          end
          lkv_pkg::FN_CLEAR: begin
            if (count_r == '0) begin
              res_sts_nxt = lkv_pkg::STS_EMPTY;
            end else begin
              count_nxt = '0;
            end
          end
          default: begin
            res_val_nxt = hit_r ? hit_val_r : '0;
          end
        endcase
      end
      S_SHIFT: begin
        // read entry i+1, write it to entry i in the next cycle
        mem_req.raddr = sh_idx_r[IW-1:0];
        mem_req.we    = pend_r;
        if (sh_idx_r < count_r) begin
          sh_idx_nxt    = sh_idx_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = sh_idx_r - 1'b1;
        end else if (!pend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_ext[31:0];
          out_found_nxt = hit_r;
          out_cnt_nxt   = cnt_ext[4:0];
          out_sts_nxt   = res_sts_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_r       <= chk_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    wval_r      <= wval_nxt;
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    hit_r       <= hit_nxt;
    pos_r       <= pos_nxt;
    hit_val_r   <= hit_val_nxt;
    res_val_r   <= res_val_nxt;
    res_sts_r   <= res_sts_nxt;
    sh_idx_r    <= sh_idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_val_r   <= out_val_nxt;
    out_found_r <= out_found_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_sts_r   <= out_sts_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sts_r, out_cnt_r, out_found_r, out_val_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lkv_pkg::CAP_CNT)
    else $error("entry count above capacity");

  a_accept_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact |=> $stable(count_r))
    else $error("entry count moved on accept");

  a_write_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_EXEC || state_r == S_SHIFT))
    else $error("memory written outside exec or shift");

  a_delete_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && state_nxt == S_RESP) |=>
      (count_r == $past(count_r) - 1'b1))
    else $error("delete did not remove exactly one entry");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && chk_r) |-> (chk_idx_r < count_r))
    else $error("scan compared an entry beyond the count");

endmodule

### bench/lkv_result_checker.sv
// ----------------------------------------------------------------------------
// lkv_result_checker
// Watches both stream channels of the key-value table core, keeps a shadow
// copy of the table to predict each result, and compares every returned
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lkv_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] func
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] wr_value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] rd_value, [32] found,
                                  // [37:33] entry_count, [39:38] status
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // msb first, so it lines up with the out_tdata layout
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        found;
    logic [31:0] rd_value;
  } table_result_t;

  logic [lkv_pkg::KEY_WIDTH-1:0]   shadow_key [lkv_pkg::CAPACITY];
  logic [lkv_pkg::VALUE_WIDTH-1:0] shadow_val [lkv_pkg::CAPACITY];
  int                     shadow_count;
  table_result_t          expected_results [$];
  table_result_t          got;
  table_result_t          want;
  int unsigned            result_index;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  // applies one operation to the shadow table and returns its result
  function automatic table_result_t table_apply(input logic [2:0] func,
                                                input logic [31:0] key,
                                                input logic [31:0] wval);
    table_result_t res;
    int            pos;
    bit            hit;
    res = '0;
    pos = 0;
    hit = 1'b0;
    for (int i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_key[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    res.found = hit;
    case (func)
      lkv_pkg::FN_ACCESS, lkv_pkg::FN_WRITE: begin
        if (!hit && shadow_count >= lkv_pkg::CAPACITY) begin
          res.status = lkv_pkg::STS_FULL;
        end else begin
          if (!hit) begin
            pos = shadow_count;
            shadow_key[pos] = key;
            shadow_val[pos] = '0;
            shadow_count++;
          end
          if (func == lkv_pkg::FN_WRITE) shadow_val[pos] = wval;
          res.rd_value = shadow_val[pos];
        end
      end
      lkv_pkg::FN_DELETE: begin
        if (shadow_count == 0) begin
          res.status = lkv_pkg::STS_EMPTY;
        end else if (!hit) begin
          res.status = lkv_pkg::STS_MISSING;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_key[i] = shadow_key[i + 1];
            shadow_val[i] = shadow_val[i + 1];
          end
          shadow_count--;
        end
      end
      lkv_pkg::FN_CLEAR: begin
        if (shadow_count == 0) res.status = lkv_pkg::STS_EMPTY;
        else shadow_count = 0;
      end
      default: begin
        // lookup, and the unused codes behave the same
        if (hit) res.rd_value = shadow_val[pos];
      end
    endcase
    res.entry_count = 5'(shadow_count);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      expected_results.delete();
      result_index = 0;
    end else begin
      // results first: a result leaving now always belongs to an older transaction
      if (out_tvalid && out_tready) begin
        got = table_result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected (tdata 0x%0h)",
                                    result_index, out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.rd_value !== want.rd_value)
            report_mismatch($sformatf("result %0d rd_value 0x%0h, expected 0x%0h",
                                      result_index, got.rd_value, want.rd_value));
          if (got.found !== want.found)
            report_mismatch($sformatf("result %0d found %0b, expected %0b",
                                      result_index, got.found, want.found));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                      result_index, got.entry_count, want.entry_count));
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      result_index, got.status, want.status));
        end
        result_index++;
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(table_apply(in_tuser, in_tdata[31:0], in_tdata[63:32]));
    end
    outstanding = expected_results.size();
  end

endmodule

### bench/linear_key_value_table_core_tb.sv
// ----------------------------------------------------------------------------
// linear_key_value_table_core_tb
// Drives lookup, access, write, delete and clear transactions into the table
// core: a directed pass over empty, full and boundary cases, then random
// traffic over a small key pool with random idling on both channels.
// ----------------------------------------------------------------------------
module linear_key_value_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_OPS   = 1900;
  localparam int POOL_SIZE    = 24;
  localparam int DRAIN_CYCLES = 60;

  // unused operation codes, which behave as lookup
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [2:0]  in_tuser   = '0;
  logic [63:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;

  int          tx_idle_pct = 23;
  int          rx_idle_pct = 45;
  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;
  logic [31:0] key_pool [POOL_SIZE];

  always #10 clk = ~clk;

  linear_key_value_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lkv_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[linear_key_value_table_core] ERROR");
      $finish;
    end
  end

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
  endtask

  // one transaction, with a random hold-off in front of it
  task automatic send_op(input logic [2:0] func, input logic [31:0] key,
                         input logic [31:0] wval);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {wval, key};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [2:0]  func;
    logic [31:0] key;
    int          r;
    bit          drain;

    refresh_pool();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table corners
    send_op(lkv_pkg::FN_LOOKUP, 32'h0000_0000, 32'h0);
    send_op(lkv_pkg::FN_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_op(lkv_pkg::FN_CLEAR, 32'h0000_0000, 32'h0);
    // insert with zero value, write the all-ones key, overwrite a hit
    send_op(lkv_pkg::FN_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(lkv_pkg::FN_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(lkv_pkg::FN_WRITE, 32'h0000_0000, 32'h5A5A_A5A5);
    send_op(lkv_pkg::FN_DELETE, 32'h8000_0001, 32'h0);
    send_op(FN_SPARE_HI, 32'hFFFF_FFFF, 32'h0);
    // fill to capacity, then try to insert into the full table
    for (int i = 2; i < lkv_pkg::CAPACITY; i++)
      send_op(lkv_pkg::FN_WRITE, 32'(i) << 27, $urandom());
    send_op(lkv_pkg::FN_ACCESS, 32'h7FFF_FFFF, 32'h0);
    send_op(lkv_pkg::FN_WRITE, 32'h0000_0001, 32'hFFFF_FFFF);
    // delete from the middle and from the front, then clear a populated table
    send_op(lkv_pkg::FN_DELETE, 32'(5) << 27, 32'h0);
    send_op(lkv_pkg::FN_DELETE, 32'h0000_0000, 32'h0);
    send_op(lkv_pkg::FN_CLEAR, 32'h0000_0000, 32'h0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 3) begin
        tx_idle_pct = 45;
        rx_idle_pct = 23;
      end else if (n == 2 * RANDOM_OPS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // alternate fill-heavy and drain-heavy stretches so the table swings
      // between empty and full
      drain = ((n / 64) % 2) == 1;
      r = $urandom_range(99);
      if (!drain) begin
        if (r < 15)      func = lkv_pkg::FN_LOOKUP;
        else if (r < 42) func = lkv_pkg::FN_ACCESS;
        else if (r < 75) func = lkv_pkg::FN_WRITE;
        else if (r < 90) func = lkv_pkg::FN_DELETE;
        else if (r < 91) func = lkv_pkg::FN_CLEAR;
        else             func = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
      end else begin
        if (r < 20)      func = lkv_pkg::FN_LOOKUP;
        else if (r < 30) func = lkv_pkg::FN_ACCESS;
        else if (r < 45) func = lkv_pkg::FN_WRITE;
        else if (r < 88) func = lkv_pkg::FN_DELETE;
        else if (r < 92) func = lkv_pkg::FN_CLEAR;
        else             func = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
      end
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else key = $urandom();
      send_op(func, key, $urandom());
      // fresh keys after a clear keep every key bit moving
      if (func == lkv_pkg::FN_CLEAR) refresh_pool();
    end
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[linear_key_value_table_core] OK");
    end else begin
      $display("[linear_key_value_table_core] ERROR");
    end
    $finish;
  end

endmodule
